>>> rtl/core/cbrf_pkg.sv
// shared types, constants and helpers for the chunked byte ring fifo
`default_nettype none

package cbrf_pkg;

  // field widths
  localparam int LEN_W  = 7;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;
  localparam int IN_DATA_W = 16;

  // default ring size and longest chunk or pop run
  localparam int DEPTH_DEF = 1024;
  localparam int MAX_CHUNK = 64;

  // item kind on the input tuser
  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  // result status on the output tuser
  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_BUSY   = 2'd2
  } status_e;

  // zero length counts as one, long requests saturate
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    len = raw;
    if (len == '0) begin
      len = LEN_W'(1);
    end
    if (len > LEN_W'(MAX_CHUNK)) begin
      len = LEN_W'(MAX_CHUNK);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cbrf_mem.sv
// byte storage of the ring: one write port, one read port, registered read data
`default_nettype none

module cbrf_mem #(
  parameter int DEPTH = cbrf_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [cbrf_pkg::BYTE_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output      logic [cbrf_pkg::BYTE_W-1:0] rdata_o
);

  logic [cbrf_pkg::BYTE_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cbrf_ctrl.sv
// sequencer: chunk admission, ring indexes, pop read-out and the output register
`default_nettype none

module cbrf_ctrl #(
  parameter int DEPTH = cbrf_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  input  wire logic [cbrf_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  wire logic                           s_axis_tuser_i,
  // result stream
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output      logic [cbrf_pkg::BYTE_W-1:0]    m_axis_tdata_o,
  output      logic [cbrf_pkg::STAT_W-1:0]    m_axis_tuser_o,
  output      logic                           m_axis_tlast_o,
  // storage port
  output      logic                           mem_we_o,
  output      logic [AW-1:0]                  mem_waddr_o,
  output      logic [cbrf_pkg::BYTE_W-1:0]    mem_wdata_o,
  output      logic                           mem_re_o,
  output      logic [AW-1:0]                  mem_raddr_o,
  input  wire logic [cbrf_pkg::BYTE_W-1:0]    mem_rdata_i
);

  localparam int LW = cbrf_pkg::LEN_W;
  localparam int SW = ((AW > LW) ? AW : LW) + 1;
  localparam logic [SW-1:0] DEPTH_X = SW'(DEPTH);
  localparam logic [SW-1:0] FREE_MAX = SW'(DEPTH - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic          state_q, state_d;
  logic [AW-1:0] wr_idx_q, wr_idx_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic [LW-1:0] off_q, off_d;
  logic [LW-1:0] remain_q, remain_d;
  logic          refused_q, refused_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [LW-1:0] rd_left_q, rd_left_d;
  logic [LW-1:0] emit_left_q, emit_left_d;
  logic          dv_q, dv_d;
  logic          ovalid_q, ovalid_d;
  logic [cbrf_pkg::BYTE_W-1:0] odata_q, odata_d;
  logic [cbrf_pkg::STAT_W-1:0] ostat_q, ostat_d;
  logic          olast_q, olast_d;

  logic          slot_free, in_acc, load;
  logic [LW-1:0] len, cnt, rem_n, off;
  logic [SW-1:0] wx, rx, lenx, occ, free_sp, asum, nsum, rsum;
  logic          first, refused, done;
  cbrf_pkg::kind_e kind;

  // input decode and ring arithmetic
  always_comb begin
    kind    = cbrf_pkg::kind_e'(s_axis_tuser_i);
    len     = cbrf_pkg::clamp_len(s_axis_tdata_i[LW-1:0]);
    lenx    = SW'(len);
    wx      = SW'(wr_idx_q);
    rx      = SW'(rd_idx_q);
    occ     = (wx >= rx) ? (wx - rx) : (wx + DEPTH_X - rx);
    free_sp = FREE_MAX - occ;
    first   = (remain_q == '0);
    refused = first ? (free_sp < lenx) : refused_q;
    cnt     = first ? len : remain_q;
    rem_n   = cnt - LW'(1);
    done    = (rem_n == '0);
    off     = first ? '0 : off_q;
    asum    = wx + SW'(off);
    if (asum >= DEPTH_X) begin
      asum = asum - DEPTH_X;
    end
    nsum    = wx + SW'(off) + SW'(1);
    if (nsum >= DEPTH_X) begin
      nsum = nsum - DEPTH_X;
    end
    rsum    = rx + lenx;
    if (rsum >= DEPTH_X) begin
      rsum = rsum - DEPTH_X;
    end
  end

  // handshake and sequencing
  always_comb begin
    slot_free = !ovalid_q || m_axis_tready_i;
    in_acc    = s_axis_tvalid_i && (state_q == S_IDLE) && slot_free;
    load      = (state_q == S_POP) && dv_q && slot_free;

    state_d     = state_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    off_d       = off_q;
    remain_d    = remain_q;
    refused_d   = refused_q;
    rd_addr_d   = rd_addr_q;
    rd_left_d   = rd_left_q;
    emit_left_d = emit_left_q;
    dv_d        = dv_q;
    odata_d     = odata_q;
    ostat_d     = ostat_q;
    olast_d     = olast_q;
    ovalid_d    = ovalid_q && !m_axis_tready_i;

    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(asum);
    mem_wdata_o = s_axis_tdata_i[LW +: cbrf_pkg::BYTE_W];
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ovalid_d = 1'b1;
          odata_d  = '0;
          olast_d  = 1'b1;
          unique case (kind)
            cbrf_pkg::KIND_PUSH: begin
              // one result per pushed byte, tail moves after the last byte of an admitted chunk
              mem_we_o = !refused;
              ostat_d  = refused ? cbrf_pkg::STAT_REJECT : cbrf_pkg::STAT_OK;
              olast_d  = done;
              remain_d = rem_n;
              if (done) begin
                if (!refused) begin
                  wr_idx_d = AW'(nsum);
                end
                off_d     = '0;
                refused_d = 1'b0;
              end else begin
                off_d     = refused ? off : off + LW'(1);
                refused_d = refused;
              end
            end
            cbrf_pkg::KIND_POP: begin
              if (!first) begin
                ostat_d = cbrf_pkg::STAT_BUSY;
              end else if (occ < lenx) begin
                ostat_d = cbrf_pkg::STAT_REJECT;
              end else begin
                // start the read-out, head moves now
                ovalid_d    = ovalid_q && !m_axis_tready_i;
                rd_addr_d   = rd_idx_q;
                rd_left_d   = len;
                emit_left_d = len;
                rd_idx_d    = AW'(rsum);
                state_d     = S_POP;
              end
            end
            default: begin
              ostat_d = cbrf_pkg::STAT_REJECT;
            end
          endcase
        end
      end
      S_POP: begin
        // move read data into the output register
        if (load) begin
          ovalid_d    = 1'b1;
          odata_d     = mem_rdata_i;
          ostat_d     = cbrf_pkg::STAT_OK;
          olast_d     = (emit_left_q == LW'(1));
          emit_left_d = emit_left_q - LW'(1);
          if (emit_left_q == LW'(1)) begin
            state_d = S_IDLE;
          end
        end
        // issue the next read once the held data is taken
        mem_re_o = (rd_left_q != '0) && (!dv_q || load);
        if (mem_re_o) begin
          rd_left_d = rd_left_q - LW'(1);
          rd_addr_d = (rd_addr_q == LAST_ADDR) ? '0 : rd_addr_q + AW'(1);
          dv_d      = 1'b1;
        end else if (load) begin
          dv_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      off_q       <= '0;
      remain_q    <= '0;
      refused_q   <= 1'b0;
      rd_left_q   <= '0;
      emit_left_q <= '0;
      dv_q        <= 1'b0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      off_q       <= off_d;
      remain_q    <= remain_d;
      refused_q   <= refused_d;
      rd_left_q   <= rd_left_d;
      emit_left_q <= emit_left_d;
      dv_q        <= dv_d;
      ovalid_q    <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    odata_q   <= odata_d;
    ostat_q   <= ostat_d;
    olast_q   <= olast_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE) && slot_free;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ostat_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

`default_nettype wire

>>> rtl/core/chunked_byte_ring_fifo_unit.sv
// Chunked byte ring fifo: top level with storage, sequencer and checks.
// Input stream: each word is a push byte (tuser 0) or a pop request (tuser 1);
// tdata carries the chunk length and the byte. A chunk is pushed one byte per
// word, its first word giving the length; the whole chunk is admitted only if
// the free space (depth minus occupancy minus one) covers it, else every byte
// comes back rejected. A pop returns that many bytes, tlast on the final one,
// or one rejection word if too little is stored, or one busy word while a
// pushed chunk is still open.
// Timing: every result leaves through one output register. A push byte or a
// single-word reply shows up the cycle after acceptance and pushes stream one
// word per cycle while the receiver takes them. A pop registers its read
// address, reads the storage port, whose read data is registered, and moves
// each byte into the output register, one per cycle while the receiver takes
// them; the next input word is taken once the last byte is in the output register.
// When the receiver stalls, the output register holds and no input is taken.
// Reset empties the ring and closes any open chunk; storage is not cleared,
// so no reset sweep is needed and input is taken right after reset.
`default_nettype none

module chunked_byte_ring_fifo_unit #(
  parameter int DEPTH = cbrf_pkg::DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  // [6:0] chunk_length, [14:7] data_in, [15] zero
  input  wire logic [cbrf_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // [0] kind
  input  wire logic                           s_axis_tuser_i,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [7:0] data_out
  output      logic [cbrf_pkg::BYTE_W-1:0]    m_axis_tdata_o,
  // [1:0] status
  output      logic [cbrf_pkg::STAT_W-1:0]    m_axis_tuser_o,
  output      logic                           m_axis_tlast_o
);

  localparam int AW = $clog2(DEPTH);

  logic                        mem_we, mem_re;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [cbrf_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;

  // sequencer
  cbrf_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  // byte storage
  cbrf_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // a busy word is always last; among non-ok words only rejected push bytes may come without tlast
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != cbrf_pkg::STAT_OK) && !m_axis_tlast_o
      |-> m_axis_tuser_o == cbrf_pkg::STAT_REJECT)
    else $error("busy word without tlast");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != cbrf_pkg::STAT_OK) |-> m_axis_tdata_o == '0)
    else $error("non-ok word carries data");

  // a stalled output register blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output is stalled");

  // status code three is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != 2'd3)
    else $error("undefined status code");

endmodule

`default_nettype wire
